### design/cctab_pkg.sv
// Shared types and constants for the circle candidate merge table.
// No dependencies; imported by every module of the block.
`default_nettype none
package cctab_pkg;

	localparam int COORD_FRAC_BITS = 4;
	localparam int TOL_PIXELS      = 15;
	localparam int MAX_RESULTS     = 16;
	localparam int WEIGHT_W        = 24;
	localparam int COORD_W         = 16;
	localparam int SUPPORT_W       = 6;

	localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = '1;

	localparam logic [23:0] CTOL_RESET = 24'(TOL_PIXELS << (2 * COORD_FRAC_BITS));
	localparam logic [15:0] RTOL_RESET = 16'(TOL_PIXELS << COORD_FRAC_BITS);
	localparam logic [4:0]  MAXREP_RESET = 5'd11;

	localparam logic FUNC_ADD    = 1'b0;
	localparam logic FUNC_FINISH = 1'b1;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_MERGED = 2'd1;
	localparam logic [1:0] ST_FULL   = 2'd2;

	localparam logic [1:0] REG_CTOL   = 2'd0;
	localparam logic [1:0] REG_RTOL   = 2'd1;
	localparam logic [1:0] REG_MAXREP = 2'd2;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic [COORD_W-1:0]        r;
		logic [WEIGHT_W-1:0]       w;
	} entry_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic [COORD_W-1:0]        r;
		logic [SUPPORT_W-1:0]      w;
	} cand_t;

endpackage
`default_nettype wire

### design/cctab_cell.sv
// One table cell of the rotating entry ring.
// Depends on cctab_pkg for the entry type.
`default_nettype none
module cctab_cell (
	input  wire                  clk,
	input  wire                  shift,
	input  wire                  load,
	input  cctab_pkg::entry_t    nb,
	input  cctab_pkg::entry_t    ldata,
	output cctab_pkg::entry_t    q
);
	import cctab_pkg::*;

	entry_t ent_q;

	always_ff @(posedge clk) begin
		if (load) begin
			ent_q <= ldata;
		end else if (shift) begin
			ent_q <= nb;
		end
	end

	assign q = ent_q;

endmodule
`default_nettype wire

### design/cctab_merge.sv
// Weighted-average merge unit: multipliers shared by the x, y and r fields and a restoring divider.
// Depends on cctab_pkg for the entry and candidate types.
`default_nettype none
module cctab_merge (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  go,
	input  cctab_pkg::entry_t    old_ent,
	input  cctab_pkg::cand_t     cand,
	output logic                 done,
	output cctab_pkg::entry_t    res
);
	import cctab_pkg::*;

	localparam logic [2:0] M_IDLE = 3'd0;
	localparam logic [2:0] M_MUL1 = 3'd1;
	localparam logic [2:0] M_MUL2 = 3'd2;
	localparam logic [2:0] M_PREP = 3'd3;
	localparam logic [2:0] M_DIV  = 3'd4;
	localparam logic [2:0] M_FIN  = 3'd5;
	localparam logic [2:0] M_DONE = 3'd6;

	logic [2:0]          st_q;
	logic [1:0]          fld_q;
	entry_t              old_q;
	cand_t               cand_q;
	logic [24:0]         sum_q;
	logic signed [41:0]  p1_q;
	logic signed [41:0]  p2_q;
	logic                neg_q;
	logic [43:0]         rem_q;
	logic [16:0]         quo_q;
	logic [4:0]          bit_q;
	logic                done_q;
	entry_t              res_q;

	logic signed [16:0]  opnd_old;
	logic signed [16:0]  opnd_new;
	logic signed [41:0]  prod_old;
	logic signed [42:0]  num;
	logic [42:0]         mag;
	logic [43:0]         dshift;
	logic [16:0]         sval;
	logic [24:0]         sum_c;

	assign sum_c = 25'(old_ent.w) + 25'(cand.w);

	always_comb begin
		case (fld_q)
			2'd0: begin
				opnd_old = 17'(old_q.x);
				opnd_new = 17'(cand_q.x);
			end
			2'd1: begin
				opnd_old = 17'(old_q.y);
				opnd_new = 17'(cand_q.y);
			end
			default: begin
				opnd_old = $signed({1'b0, old_q.r});
				opnd_new = $signed({1'b0, cand_q.r});
			end
		endcase
		prod_old = opnd_old * $signed({1'b0, old_q.w});
		num    = 43'(p1_q) + 43'(p2_q);
		mag    = num[42] ? 43'(-num) : 43'(num);
		dshift = 44'(sum_q) << bit_q;
		sval   = neg_q ? 17'(-quo_q) : quo_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= M_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (st_q)
				M_IDLE: begin
					if (go) begin
						st_q <= (sum_c == 25'd0) ? M_DONE : M_MUL1;
					end
				end
				M_MUL1: st_q <= M_MUL2;
				M_MUL2: st_q <= M_PREP;
				M_PREP: st_q <= M_DIV;
				M_DIV: begin
					if (bit_q == 5'd0) begin
						st_q <= M_FIN;
					end
				end
				M_FIN: st_q <= (fld_q == 2'd2) ? M_DONE : M_MUL1;
				M_DONE: begin
					done_q <= 1'b1;
					st_q   <= M_IDLE;
				end
				default: st_q <= M_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			M_IDLE: begin
				if (go) begin
					old_q  <= old_ent;
					cand_q <= cand;
					sum_q  <= sum_c;
					res_q  <= old_ent;
					fld_q  <= 2'd0;
				end
			end
			M_MUL1: p1_q <= prod_old;
			M_MUL2: p2_q <= 42'(opnd_new * $signed({19'b0, cand_q.w}));
			M_PREP: begin
				neg_q <= num[42];
				rem_q <= 44'(mag) + 44'(sum_q >> 1);
				quo_q <= '0;
				bit_q <= 5'd16;
			end
			M_DIV: begin
				if (rem_q >= dshift) begin
					rem_q        <= rem_q - dshift;
					quo_q[bit_q] <= 1'b1;
				end
				bit_q <= bit_q - 5'd1;
			end
			M_FIN: begin
				case (fld_q)
					2'd0:    res_q.x <= sval[15:0];
					2'd1:    res_q.y <= sval[15:0];
					default: begin
						res_q.r <= sval[15:0];
						res_q.w <= (sum_q > 25'(WEIGHT_MAX)) ? WEIGHT_MAX : sum_q[23:0];
					end
				endcase
				fld_q <= fld_q + 2'd1;
			end
			default: ;
		endcase
	end

	assign done = done_q;
	assign res  = res_q;

endmodule
`default_nettype wire

### design/circle_candidate_merge_table.sv
// Top level: rotating ring of table cells, scan compare pipeline and control.
// Depends on cctab_pkg, cctab_cell and cctab_merge.
//
// Accumulator of a randomized Hough transform for circles. Entries live in a
// ring of TABLE_DEPTH cells that rotates one place per cycle, while the
// control steps it, past a single head cell, where all comparisons and updates
// happen. An add scans the filled entries, rotates the ring to the target
// entry, if any, and back home, and waits while a merge runs the merge unit's
// multipliers and the 17-step divider; it returns exactly one result. A finish
// makes a full selection pass over the ring for each reported circle, and
// clears the table. Results are single-cycle strobes and cannot be stalled.
// busy is high while an item is in work; configuration writes are always accepted.
`default_nettype none
module circle_candidate_merge_table #(
	parameter int TABLE_DEPTH = 64
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                start,
	output logic               busy,
	input  wire                func,
	input  wire signed [15:0]  center_x,
	input  wire signed [15:0]  center_y,
	input  wire [15:0]         radius,
	input  wire [5:0]          support,
	input  wire                cfg_valid,
	output logic               cfg_ready,
	input  wire [1:0]          cfg_index,
	input  wire [23:0]         cfg_data,
	output logic               strobe,
	output logic signed [15:0] out_x,
	output logic signed [15:0] out_y,
	output logic [15:0]        out_radius,
	output logic [23:0]        out_weight,
	output logic               out_valid,
	output logic               out_last,
	output logic [1:0]         status
);
	import cctab_pkg::*;

	localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int LW = (CW > 5) ? CW : 5;
	localparam logic [IW-1:0] LAST_OFF = IW'(TABLE_DEPTH - 1);

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_SCAN    = 4'd1;
	localparam logic [3:0] S_DRAIN   = 4'd2;
	localparam logic [3:0] S_DECIDE  = 4'd3;
	localparam logic [3:0] S_SEEK    = 4'd4;
	localparam logic [3:0] S_MERGE   = 4'd5;
	localparam logic [3:0] S_HOME    = 4'd6;
	localparam logic [3:0] S_SORT    = 4'd7;
	localparam logic [3:0] S_SORTOUT = 4'd8;

	logic [3:0]     state_q;
	logic [IW-1:0]  off_q;
	logic [CW-1:0]  count_q;
	logic [23:0]    ctol_q;
	logic [15:0]    rtol_q;
	logic [4:0]     mr_q;
	cand_t          cand_q;
	logic           found_q;
	logic           merge_q;
	logic [IW-1:0]  tgt_q;
	logic [4:0]     lim_q;
	logic [4:0]     k_q;
	logic           bfound_q;
	logic           havep_q;
	entry_t         best_q;
	logic [IW-1:0]  bidx_q;
	logic [23:0]    pw_q;
	logic [IW-1:0]  pidx_q;

	logic               v_s1, v_s2, v_s3;
	logic [IW-1:0]      idx_s1, idx_s2, idx_s3;
	logic signed [16:0] dx_s1, dy_s1;
	logic [15:0]        dr_s1;
	logic [31:0]        dx2_s2, dy2_s2;
	logic               rok_s2;
	logic               match_s3;

	logic           strobe_q;
	entry_t         oent_q;
	logic           ovalid_q, olast_q;
	logic [1:0]     ostat_q;

	entry_t         ring [TABLE_DEPTH];
	entry_t         head;
	logic           rot;
	logic           head_load;
	entry_t         head_data;
	logic           issue;
	logic           mgo;
	logic           mdone;
	entry_t         mres;
	logic signed [16:0] drs;
	logic [4:0]     lim0;
	logic [LW-1:0]  cnt_ext;
	logic           head_in;
	logic           head_after;

	assign head = ring[0];

	genvar g;
	generate
		for (g = 0; g < TABLE_DEPTH; g++) begin : g_cell
			localparam int NXT = (g + 1) % TABLE_DEPTH;
			if (g == 0) begin : g_head
				cctab_cell u_cell (
					.clk   (clk),
					.shift (rot),
					.load  (head_load),
					.nb    (ring[NXT]),
					.ldata (head_data),
					.q     (ring[g])
				);
			end else begin : g_body
				cctab_cell u_cell (
					.clk   (clk),
					.shift (rot),
					.load  (1'b0),
					.nb    (ring[NXT]),
					.ldata (head_data),
					.q     (ring[g])
				);
			end
		end
	endgenerate

	cctab_merge u_merge (
		.clk     (clk),
		.arst_n  (arst_n),
		.go      (mgo),
		.old_ent (head),
		.cand    (cand_q),
		.done    (mdone),
		.res     (mres)
	);

	always_comb begin
		lim0 = (mr_q == 5'd0) ? 5'd1 :
		       (mr_q > 5'(MAX_RESULTS)) ? 5'(MAX_RESULTS) : mr_q;
		cnt_ext = LW'(count_q);
		head_in = CW'(off_q) < count_q;
		head_after = !havep_q || (head.w < pw_q) || ((head.w == pw_q) && (off_q > pidx_q));
		issue = (state_q == S_SCAN) && !found_q;
		rot = issue
		   || ((state_q == S_SEEK) && (off_q != tgt_q))
		   || ((state_q == S_HOME) && (off_q != '0))
		   || (state_q == S_SORT);
		head_load = 1'b0;
		head_data = mres;
		mgo = 1'b0;
		if (state_q == S_SEEK && off_q == tgt_q) begin
			if (merge_q) begin
				mgo = 1'b1;
			end else begin
				head_load = 1'b1;
				head_data = '{x: cand_q.x, y: cand_q.y, r: cand_q.r, w: 24'(cand_q.w)};
			end
		end else if (state_q == S_MERGE && mdone) begin
			head_load = 1'b1;
		end
		drs = $signed({1'b0, cand_q.r}) - $signed({1'b0, head.r});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctol_q <= CTOL_RESET;
			rtol_q <= RTOL_RESET;
			mr_q   <= MAXREP_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_CTOL:   ctol_q <= cfg_data;
				REG_RTOL:   rtol_q <= cfg_data[15:0];
				REG_MAXREP: mr_q   <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1   <= off_q;
		dx_s1    <= 17'(cand_q.x) - 17'(head.x);
		dy_s1    <= 17'(cand_q.y) - 17'(head.y);
		dr_s1    <= drs[16] ? 16'(-drs) : drs[15:0];
		idx_s2   <= idx_s1;
		dx2_s2   <= 32'(dx_s1 * dx_s1);
		dy2_s2   <= 32'(dy_s1 * dy_s1);
		rok_s2   <= dr_s1 < rtol_q;
		idx_s3   <= idx_s2;
		match_s3 <= rok_s2 && ((33'(dx2_s2) + 33'(dy2_s2)) < 33'(ctol_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			off_q    <= '0;
			count_q  <= '0;
			found_q  <= 1'b0;
			merge_q  <= 1'b0;
			bfound_q <= 1'b0;
			havep_q  <= 1'b0;
			k_q      <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			if (rot) begin
				off_q <= (off_q == LAST_OFF) ? '0 : off_q + IW'(1);
			end
			if (v_s3 && match_s3 && !found_q) begin
				found_q <= 1'b1;
				tgt_q   <= idx_s3;
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						cand_q  <= '{x: center_x, y: center_y, r: radius, w: support};
						found_q <= 1'b0;
						if (func == FUNC_ADD) begin
							state_q <= (count_q == '0) ? S_DECIDE : S_SCAN;
						end else if (count_q == '0) begin
							strobe_q <= 1'b1;
							oent_q   <= '0;
							ovalid_q <= 1'b0;
							olast_q  <= 1'b1;
							ostat_q  <= ST_OK;
						end else begin
							lim_q    <= (cnt_ext < LW'(lim0)) ? cnt_ext[4:0] : lim0;
							k_q      <= '0;
							havep_q  <= 1'b0;
							bfound_q <= 1'b0;
							state_q  <= S_SORT;
						end
					end
				end
				S_SCAN: begin
					if (found_q || (CW'(off_q) + CW'(1)) == count_q) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					if (!v_s1 && !v_s2 && !v_s3) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					if (found_q) begin
						merge_q <= 1'b1;
						state_q <= S_SEEK;
					end else if (count_q == CW'(TABLE_DEPTH)) begin
						strobe_q <= 1'b1;
						oent_q   <= '0;
						ovalid_q <= 1'b0;
						olast_q  <= 1'b0;
						ostat_q  <= ST_FULL;
						state_q  <= S_HOME;
					end else begin
						merge_q <= 1'b0;
						tgt_q   <= count_q[IW-1:0];
						state_q <= S_SEEK;
					end
				end
				S_SEEK: begin
					if (off_q == tgt_q) begin
						if (merge_q) begin
							state_q <= S_MERGE;
						end else begin
							count_q  <= count_q + CW'(1);
							strobe_q <= 1'b1;
							oent_q   <= head_data;
							ovalid_q <= 1'b1;
							olast_q  <= 1'b0;
							ostat_q  <= ST_OK;
							state_q  <= S_HOME;
						end
					end
				end
				S_MERGE: begin
					if (mdone) begin
						strobe_q <= 1'b1;
						oent_q   <= mres;
						ovalid_q <= 1'b1;
						olast_q  <= 1'b0;
						ostat_q  <= ST_MERGED;
						state_q  <= S_HOME;
					end
				end
				S_HOME: begin
					if (off_q == '0) begin
						state_q <= S_IDLE;
					end
				end
				S_SORT: begin
					if (head_in && head_after && (!bfound_q || head.w > best_q.w)) begin
						best_q   <= head;
						bidx_q   <= off_q;
						bfound_q <= 1'b1;
					end
					if (off_q == LAST_OFF) begin
						state_q <= S_SORTOUT;
					end
				end
				S_SORTOUT: begin
					strobe_q <= 1'b1;
					oent_q   <= best_q;
					ovalid_q <= 1'b1;
					olast_q  <= (k_q + 5'd1) == lim_q;
					ostat_q  <= ST_OK;
					pw_q     <= best_q.w;
					pidx_q   <= bidx_q;
					havep_q  <= 1'b1;
					bfound_q <= 1'b0;
					k_q      <= k_q + 5'd1;
					if ((k_q + 5'd1) == lim_q) begin
						count_q <= '0;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_SORT;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy       = state_q != S_IDLE;
	assign cfg_ready  = 1'b1;
	assign strobe     = strobe_q;
	assign out_x      = oent_q.x;
	assign out_y      = oent_q.y;
	assign out_radius = oent_q.r;
	assign out_weight = oent_q.w;
	assign out_valid  = ovalid_q;
	assign out_last   = olast_q;
	assign status     = ostat_q;

	a_home_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (off_q == '0))
		else $error("ring not at home while idle");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(TABLE_DEPTH))
		else $error("entry count beyond table depth");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe_q && olast_q) |-> (count_q == '0))
		else $error("table not cleared after last report");

	a_merge_target: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SEEK && merge_q) |-> (CW'(tgt_q) < count_q))
		else $error("merge target outside filled entries");

endmodule
`default_nettype wire

### tb/testbench.sv
// Self-checking testbench for circle_candidate_merge_table.
// Drives add and finish items with random pacing and predicts every result from
// a behavioral copy of the circle table; depends on cctab_pkg and the design.
`timescale 1ns / 1ps
module testbench;
	import cctab_pkg::*;

	localparam int DEPTH = 64;
	localparam logic [1:0] REG_NONE = 2'd3;

	typedef struct {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic [15:0]        r;
		logic [23:0]        w;
		logic               v;
		logic               l;
		logic [1:0]         st;
	} circle_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic func = FUNC_ADD;
	logic signed [15:0] center_x = '0;
	logic signed [15:0] center_y = '0;
	logic [15:0] radius = '0;
	logic [5:0] support = '0;
	logic cfg_valid = 1'b0;
	logic [1:0] cfg_index = REG_CTOL;
	logic [23:0] cfg_data = '0;
	wire busy, cfg_ready, strobe, out_valid, out_last;
	wire signed [15:0] out_x, out_y;
	wire [15:0] out_radius;
	wire [23:0] out_weight;
	wire [1:0] status;

	circle_candidate_merge_table dut (.*);

	always #2 clk = ~clk;

	logic signed [15:0] tab_x[DEPTH];
	logic signed [15:0] tab_y[DEPTH];
	logic [15:0] tab_r[DEPTH];
	logic [23:0] tab_w[DEPTH];
	int unsigned tab_count;
	logic [23:0] ctol;
	logic [15:0] rtol;
	logic [4:0] maxrep;

	circle_res_t pending_circles[$];
	int mismatches = 0;
	int idle_cycles = 0;
	bit failed;

	function automatic longint round_avg(longint a, longint wa, longint b, longint wb);
		longint num, s;
		num = a * wa + b * wb;
		s = wa + wb;
		if (num >= 0) return (num + s / 2) / s;
		return -((-num + s / 2) / s);
	endfunction

	function automatic circle_res_t mk(logic signed [15:0] x, logic signed [15:0] y,
		logic [15:0] r, logic [23:0] w, logic v, logic l, logic [1:0] st);
		circle_res_t c;
		c.x = x; c.y = y; c.r = r; c.w = w; c.v = v; c.l = l; c.st = st;
		return c;
	endfunction

	task automatic queue_result(circle_res_t c);
		pending_circles = {pending_circles, c};
	endtask

	task automatic predict_add(logic signed [15:0] x, logic signed [15:0] y,
		logic [15:0] r, logic [5:0] s);
		longint dx, dy, dr, sum;
		longint unsigned d2;
		for (int i = 0; i < tab_count; i++) begin
			dx = longint'(x) - longint'(tab_x[i]);
			dy = longint'(y) - longint'(tab_y[i]);
			d2 = dx * dx + dy * dy;
			dr = longint'(r) - longint'(tab_r[i]);
			if (dr < 0) dr = -dr;
			if (d2 < ctol && dr < rtol) begin
				sum = longint'(tab_w[i]) + s;
				if (sum != 0) begin
					tab_x[i] = 16'(round_avg(tab_x[i], tab_w[i], x, s));
					tab_y[i] = 16'(round_avg(tab_y[i], tab_w[i], y, s));
					tab_r[i] = 16'(round_avg(longint'(tab_r[i]), tab_w[i], longint'(r), s));
					tab_w[i] = sum > 24'hFFFFFF ? WEIGHT_MAX : 24'(sum);
				end
				queue_result(mk(tab_x[i], tab_y[i], tab_r[i], tab_w[i], 1, 0, ST_MERGED));
				return;
			end
		end
		if (tab_count >= DEPTH) begin
			queue_result(mk(0, 0, 0, 0, 0, 0, ST_FULL));
			return;
		end
		tab_x[tab_count] = x; tab_y[tab_count] = y;
		tab_r[tab_count] = r; tab_w[tab_count] = 24'(s);
		tab_count++;
		queue_result(mk(x, y, r, 24'(s), 1, 0, ST_OK));
	endtask

	task automatic predict_finish();
		int order[DEPTH];
		int lim, k, v;
		if (tab_count == 0) begin
			queue_result(mk(0, 0, 0, 0, 0, 1, ST_OK));
			return;
		end
		for (int i = 0; i < tab_count; i++) order[i] = i;
		for (int i = 1; i < tab_count; i++) begin
			v = order[i];
			k = i;
			while (k > 0 && tab_w[v] > tab_w[order[k-1]]) begin
				order[k] = order[k-1];
				k--;
			end
			order[k] = v;
		end
		lim = maxrep;
		if (lim < 1) lim = 1;
		if (lim > MAX_RESULTS) lim = MAX_RESULTS;
		if (lim > tab_count) lim = tab_count;
		for (int j = 0; j < lim; j++)
			queue_result(mk(tab_x[order[j]], tab_y[order[j]], tab_r[order[j]],
				tab_w[order[j]], 1, j + 1 == lim, ST_OK));
		tab_count = 0;
	endtask

	task automatic send_item(logic f, logic signed [15:0] x, logic signed [15:0] y,
		logic [15:0] r, logic [5:0] s);
		int gap;
		gap = $urandom_range(0, 5);
		@(negedge clk);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		func <= f; center_x <= x; center_y <= y; radius <= r; support <= s;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		if (f == FUNC_ADD) predict_add(x, y, r, s);
		else predict_finish();
	endtask

	task automatic drain();
		@(negedge clk);
		start <= 1'b0;
		while (pending_circles.size() != 0) @(negedge clk);
		repeat (300) @(negedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [23:0] d);
		drain();
		cfg_index <= idx; cfg_data <= d; cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_CTOL:   ctol = d;
			REG_RTOL:   rtol = d[15:0];
			REG_MAXREP: maxrep = d[4:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic add_rand_near(int unsigned spread);
		logic signed [15:0] bx, by;
		logic [15:0] br;
		bx = 16'($urandom_range(0, 4000)) - 16'sd2000;
		by = 16'($urandom_range(0, 4000)) - 16'sd2000;
		br = 16'($urandom_range(100, 3000));
		send_item(FUNC_ADD, bx + 16'($urandom_range(0, spread)),
			by + 16'($urandom_range(0, spread)), br + 16'($urandom_range(0, spread)),
			6'($urandom));
	endtask

	task automatic test_directed();
		send_item(FUNC_FINISH, 0, 0, 0, 0);
		send_item(FUNC_ADD, 16'sh7FFF, 16'sh8000, 16'hFFFF, 6'd63);
		send_item(FUNC_ADD, 16'sh7FF0, 16'sh8008, 16'hFFF0, 6'd63);
		send_item(FUNC_ADD, 16'sh8000, 16'sh7FFF, 16'h0000, 6'd0);
		send_item(FUNC_ADD, 16'sh8004, 16'sh7FFF, 16'h0004, 6'd0);
		send_item(FUNC_ADD, -16'sd5, 16'sd3, 16'd100, 6'd1);
		send_item(FUNC_ADD, 16'sd4, -16'sd3, 16'd105, 6'd2);
		send_item(FUNC_ADD, 16'sd0, 16'sd0, 16'd500, 6'd7);
		send_item(FUNC_ADD, 16'sd1000, 16'sd1000, 16'd500, 6'd7);
		send_item(FUNC_FINISH, 16'sh7FFF, 16'sh7FFF, 16'hFFFF, 6'd63);
	endtask

	task automatic test_full_table();
		for (int i = 0; i < 66; i++)
			send_item(FUNC_ADD, 16'(i * 300), 16'(-i * 200), 16'(i * 50), 6'($urandom));
		send_item(FUNC_FINISH, 0, 0, 0, 0);
	endtask

	task automatic test_saturation();
		write_reg(REG_CTOL, 24'hFFFFFF);
		write_reg(REG_RTOL, 16'hFFFF);
		write_reg(REG_MAXREP, 5'd16);
		for (int i = 0; i < 20; i++) add_rand_near(65535);
		send_item(FUNC_FINISH, 0, 0, 0, 0);
	endtask

	task automatic test_report_limits();
		write_reg(REG_CTOL, 24'd0);
		write_reg(REG_RTOL, 16'd0);
		write_reg(REG_MAXREP, 5'd0);
		for (int i = 0; i < 5; i++) add_rand_near(10);
		send_item(FUNC_FINISH, 0, 0, 0, 0);
		write_reg(REG_MAXREP, 5'd31);
		for (int i = 0; i < 20; i++) add_rand_near(4000);
		send_item(FUNC_FINISH, 0, 0, 0, 0);
		write_reg(REG_NONE, 24'hABCDEF);
	endtask

	task automatic test_random();
		int frame;
		for (int p = 0; p < 3; p++) begin
			write_reg(REG_CTOL, 24'($urandom_range(0, 20000)));
			write_reg(REG_RTOL, 16'($urandom_range(0, 400)));
			write_reg(REG_MAXREP, 5'($urandom_range(1, 16)));
			for (int f = 0; f < 4; f++) begin
				frame = $urandom_range(3, 14);
				for (int i = 0; i < frame; i++) begin
					if ($urandom_range(0, 9) == 0)
						send_item(FUNC_ADD, 16'($urandom), 16'($urandom), 16'($urandom),
							6'($urandom));
					else
						add_rand_near(60);
				end
				send_item(FUNC_FINISH, 16'($urandom), 16'($urandom), 16'($urandom),
					6'($urandom));
			end
		end
	endtask

	always @(posedge clk) begin
		circle_res_t e;
		if (strobe) begin
			if (pending_circles.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result at %0t got %0d %0d %0d %0d v%0b l%0b s%0d",
						$realtime, out_x, out_y, out_radius, out_weight, out_valid,
						out_last, status);
			end else begin
				e = pending_circles.pop_front();
				if (out_x !== e.x || out_y !== e.y || out_radius !== e.r ||
					out_weight !== e.w || out_valid !== e.v || out_last !== e.l ||
					status !== e.st) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch exp %0d %0d %0d %0d v%0b l%0b s%0d got %0d %0d %0d %0d v%0b l%0b s%0d",
							e.x, e.y, e.r, e.w, e.v, e.l, e.st, out_x, out_y, out_radius,
							out_weight, out_valid, out_last, status);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (strobe || (start && !busy) || (cfg_valid && cfg_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 20000) begin
			$display("circle_candidate_merge_table verification failed");
			$finish;
		end
	end

	initial begin
		ctol = CTOL_RESET;
		rtol = RTOL_RESET;
		maxrep = MAXREP_RESET;
		tab_count = 0;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		drain();
		test_full_table();
		test_saturation();
		test_report_limits();
		test_random();
		drain();
		failed = mismatches != 0 || pending_circles.size() != 0;
		if (!failed)
			$display("circle_candidate_merge_table verification clean");
		else
			$display("circle_candidate_merge_table verification failed");
		$finish;
	end

endmodule

### files.f
design/cctab_pkg.sv
design/cctab_cell.sv
design/cctab_merge.sv
design/circle_candidate_merge_table.sv
tb/testbench.sv
